// ===== src/flow_vector_to_color_core_defines.svh =====
// assertion macros for the flow to color core
`ifndef FLOW_VECTOR_TO_COLOR_CORE_DEFINES_SVH
`define FLOW_VECTOR_TO_COLOR_CORE_DEFINES_SVH

`define FVC_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

`define FVC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ===== src/fvc_pkg.sv =====
package fvc_pkg;
   localparam int VEC_FRAC_BITS_DEF = 5;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN = 24;
   localparam int CW = 40;
   localparam int SQ_STAGES = 32;

   typedef enum logic [0:0] {
      CSR_SHOW_MODE = 1'b0,
      CSR_GAIN      = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] gain;
   } cfg_type;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] t [ATAN_LEN] = '{
         32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
         32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
         32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
         32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};
      return t[i];
   endfunction
endpackage

// ===== src/fvc_cordic_cell.sv =====
module fvc_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [fvc_pkg::CW-1:0] x_in,
   input  logic signed [fvc_pkg::CW-1:0] y_in,
   input  logic [31:0]                 z_in,
   output logic signed [fvc_pkg::CW-1:0] x_ff,
   output logic signed [fvc_pkg::CW-1:0] y_ff,
   output logic [31:0]                 z_ff
);
   logic signed [fvc_pkg::CW-1:0] dx, dy;
   assign dx = y_in >>> STAGE;
   assign dy = x_in >>> STAGE;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (!y_in[fvc_pkg::CW-1]) begin
            x_ff <= x_in + dx;
            y_ff <= y_in - dy;
            z_ff <= z_in + fvc_pkg::atan_turn(STAGE);
         end else begin
            x_ff <= x_in - dx;
            y_ff <= y_in + dy;
            z_ff <= z_in - fvc_pkg::atan_turn(STAGE);
         end
      end
   end
endmodule

// ===== src/fvc_sqrt_cell.sv =====
module fvc_sqrt_cell #(
   parameter int STAGE = 0
) (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] n_in,
   input  logic [63:0] r_in,
   output logic [63:0] n_ff,
   output logic [63:0] r_ff
);
   localparam int SH = 62 - 2 * STAGE;
   logic [63:0] b, rb;
   assign b  = 64'd1 << SH;
   assign rb = r_in + b;
   always_ff @(posedge clock) begin
      if (advance) begin
         if (n_in >= rb) begin
            n_ff <= n_in - rb;
            r_ff <= (r_in >> 1) + b;
         end else begin
            n_ff <= n_in;
            r_ff <= r_in >> 1;
         end
      end
   end
endmodule

// ===== src/flow_vector_to_color_core.sv =====
// one pixel per cycle, full throughput: an item is accepted every clock while the
// result side takes results. The 32-cell square-root chain, which runs beside the
// CORDIC_STAGES-cell angle chain, sets the depth of the pipe. The whole pipe stalls
// together when the result is not taken.
module flow_vector_to_color_core #(
   parameter int VEC_FRAC_BITS = fvc_pkg::VEC_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = fvc_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // flow_x, flow_y, cost_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // red, green, blue, gray
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int CW = fvc_pkg::CW;
   localparam int SQ = fvc_pkg::SQ_STAGES;
   localparam int LAT = SQ + 5;
   localparam int SHV = 2 * VEC_FRAC_BITS + 5;

   fvc_pkg::cfg_type cfg_ff;
   logic adv;
   logic [LAT-1:0] vld_ff;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 1'b0, gain: 16'd256};
         vld_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (fvc_pkg::csr_index_type'(csr_index))
               fvc_pkg::CSR_SHOW_MODE: cfg_ff.mode <= csr_data[0];
               fvc_pkg::CSR_GAIN:      cfg_ff.gain <= csr_data;
               default: ;
            endcase
         end
         if (adv) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   logic signed [15:0] fx, fy;
   logic [15:0] cst;
   assign fx = req_tdata[15:0];
   assign fy = req_tdata[31:16];
   assign cst = req_tdata[47:32];

   // stage 0: squares, cordic entry, gray
   logic [31:0] len2_ff;
   logic [31:0] gg_ff;
   logic [15:0] gray_ff [LAT];
   logic        mode_ff [LAT];
   logic signed [CW-1:0] cx [CORDIC_STAGES+1];
   logic signed [CW-1:0] cy [CORDIC_STAGES+1];
   logic [31:0] cz [CORDIC_STAGES+1];
   logic        zero_ff;
   logic signed [CW-1:0] x0, y0;
   logic [31:0] prod;
   assign x0 = CW'(fx) <<< 8;
   assign y0 = -(CW'(fy) <<< 8);
   assign prod = cst * cfg_ff.gain;

   always_ff @(posedge clock) begin
      if (adv) begin
         len2_ff <= 32'(fx * fx) + 32'(fy * fy);
         gg_ff <= cfg_ff.gain * cfg_ff.gain;
         zero_ff <= (fx == 16'sd0) && (fy == 16'sd0);
         gray_ff[0] <= (prod >= 32'd65535) ? 16'd65535 : prod[15:0];
         mode_ff[0] <= cfg_ff.mode;
         if (x0 < 0) begin
            cx[0] <= -x0; cy[0] <= -y0; cz[0] <= 32'h8000_0000;
         end else begin
            cx[0] <= x0; cy[0] <= y0; cz[0] <= 32'd0;
         end
         for (int k = 1; k < LAT; k++) begin
            gray_ff[k] <= gray_ff[k-1];
            mode_ff[k] <= mode_ff[k-1];
         end
      end
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      fvc_cordic_cell #(.STAGE(g)) u_cell (
         .clock(clock), .advance(adv), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
         .x_ff(cx[g+1]), .y_ff(cy[g+1]), .z_ff(cz[g+1]));
   end

   // zero flag delay to cordic end
   logic zd_ff [CORDIC_STAGES];
   always_ff @(posedge clock) begin
      if (adv) begin
         zd_ff[0] <= zero_ff;
         for (int k = 1; k < CORDIC_STAGES; k++) zd_ff[k] <= zd_ff[k-1];
      end
   end

   // hue delay to sqrt end (cordic out is cz[CORDIC_STAGES])
   localparam int HD = SQ + 2 - (CORDIC_STAGES + 1);
   logic [31:0] hz_ff [HD];
   always_ff @(posedge clock) begin
      if (adv) begin
         hz_ff[0] <= zd_ff[CORDIC_STAGES-1] ? 32'd0 : cz[CORDIC_STAGES];
         for (int k = 1; k < HD; k++) hz_ff[k] <= hz_ff[k-1];
      end
   end

   // stage 1: n = len2*gain^2 >> SHV
   logic [63:0] sn [SQ+1];
   logic [63:0] sr [SQ+1];
   logic [63:0] nfull;
   assign nfull = len2_ff * gg_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         sn[0] <= nfull >> SHV;
         sr[0] <= '0;
      end
   end
   for (genvar g = 0; g < SQ; g++) begin : g_sqrt
      fvc_sqrt_cell #(.STAGE(g)) u_cell (
         .clock(clock), .advance(adv), .n_in(sn[g]), .r_in(sr[g]),
         .n_ff(sn[g+1]), .r_ff(sr[g+1]));
   end

   // stage SQ+2: s and sector fraction
   logic [16:0] s_ff;
   logic [2:0]  sec_ff;
   logic [15:0] f_ff;
   logic [34:0] h6;
   assign h6 = 35'(hz_ff[HD-1]) * 35'd6;
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= (sr[SQ] > 64'd65536) ? 17'd65536 : sr[SQ][16:0];
         sec_ff <= h6[34:32];
         f_ff <= h6[31:16];
      end
   end

   // stage SQ+3: p q t
   logic [16:0] p_ff, q_ff, t_ff;
   logic [2:0]  sec2_ff;
   logic [33:0] sf, sfn;
   assign sf  = s_ff * f_ff;
   assign sfn = s_ff * (17'd65536 - {1'b0, f_ff});
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= 17'd65536 - s_ff;
         q_ff <= 17'd65536 - sf[32:16];
         t_ff <= 17'd65536 - sfn[32:16];
         sec2_ff <= sec_ff;
      end
   end

   // stage SQ+4: channel select
   logic [16:0] rc, gc, bc;
   logic [24:0] r8, g8, b8;
   logic [7:0]  red_ff, green_ff, blue_ff;
   always_comb begin
      unique case (sec2_ff)
         3'd0: begin rc = 17'd65536; gc = t_ff; bc = p_ff; end
         3'd1: begin rc = q_ff; gc = 17'd65536; bc = p_ff; end
         3'd2: begin rc = p_ff; gc = 17'd65536; bc = t_ff; end
         3'd3: begin rc = p_ff; gc = q_ff; bc = 17'd65536; end
         3'd4: begin rc = t_ff; gc = p_ff; bc = 17'd65536; end
         default: begin rc = 17'd65536; gc = p_ff; bc = q_ff; end
      endcase
   end
   assign r8 = rc * 8'd255;
   assign g8 = gc * 8'd255;
   assign b8 = bc * 8'd255;
   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff <= r8[23:16];
         green_ff <= g8[23:16];
         blue_ff <= b8[23:16];
      end
   end

   logic md;
   assign md = mode_ff[LAT-1];
   assign rsp_tdata = {gray_ff[LAT-1] & {16{md}},
                       blue_ff & {8{!md}}, green_ff & {8{!md}}, red_ff & {8{!md}}};
endmodule

// ===== src/fvc_checker.sv =====
`include "flow_vector_to_color_core_defines.svh"
module fvc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   `FVC_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `FVC_ASSERT_IMPL(a_ready, clock, reset, rsp_tready, req_tready)
   `FVC_ASSERT_IMPL(a_excl, clock, reset, rsp_tvalid, (~|rsp_tdata[39:24]) || (~|rsp_tdata[23:0]))
   `FVC_ASSERT_NEXT(a_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
endmodule

bind flow_vector_to_color_core fvc_checker u_fvc_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

// ===== tb/tb_flow_vector_to_color_core.sv =====
`timescale 1ns / 100ps

module tb_flow_vector_to_color_core;

   localparam int LATENCY = fvc_pkg::SQ_STAGES + 5;
   localparam logic [31:0] ARC_TURN [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] gray;
   } pixel_color_type;

   typedef struct {
      logic [15:0]     fx;
      logic [15:0]     fy;
      logic [15:0]     cost;
      logic            known;
      pixel_color_type color;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [15:0] csr_data;

   pixel_color_type color_queue[$];
   int              error_count;
   int              send_idle_pct;
   int              stall_pct;
   logic            view_cost;
   logic [15:0]     view_gain;

   flow_vector_to_color_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [31:0] flow_hue(logic signed [15:0] x, logic signed [15:0] y);
      longint cx;
      longint cy;
      longint dx;
      longint dy;
      logic [31:0] z;
      cx = longint'(x) * 256;
      cy = -longint'(y) * 256;
      z = 32'd0;
      if (x == 0 && y == 0) begin
         return 32'd0;
      end
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(cy, i);
         dy = floor_shift(cx, i);
         if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            z += ARC_TURN[i];
         end else begin
            cx -= dx;
            cy += dy;
            z -= ARC_TURN[i];
         end
      end
      return z;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [7:0] to_byte(logic [31:0] c);
      logic [63:0] w;
      w = (64'(c) * 64'd255) >> 16;
      return w[7:0];
   endfunction

   function automatic pixel_color_type color_of_pixel(logic [15:0] fx, logic [15:0] fy,
                                                      logic [15:0] cost);
      pixel_color_type res;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [63:0] len2;
      logic [63:0] root;
      logic [31:0] sat;
      logic [63:0] h6;
      logic [31:0] sector;
      logic [31:0] f;
      logic [31:0] p;
      logic [31:0] q;
      logic [31:0] t;
      logic [31:0] v;
      logic [31:0] r;
      logic [31:0] g;
      logic [31:0] b;
      logic [63:0] prod;
      res = '0;
      if (view_cost) begin
         prod = 64'(cost) * 64'(view_gain);
         res.gray = (prod >= 64'd65535) ? 16'hFFFF : prod[15:0];
         return res;
      end
      x = fx;
      y = fy;
      len2 = 64'(longint'(x) * longint'(x) + longint'(y) * longint'(y));
      root = int_sqrt((len2 * (64'(view_gain) * 64'(view_gain))) >> 15);
      sat = (root > 64'd65536) ? 32'd65536 : root[31:0];
      h6 = (64'(flow_hue(x, y)) * 64'd6) >> 16;
      sector = 32'(h6 >> 16);
      f = 32'(h6 & 64'hFFFF);
      v = 32'd65536;
      p = v - sat;
      q = v - 32'((64'(sat) * 64'(f)) >> 16);
      t = v - 32'((64'(sat) * 64'(32'd65536 - f)) >> 16);
      unique case (sector)
         0: begin r = v; g = t; b = p; end
         1: begin r = q; g = v; b = p; end
         2: begin r = p; g = v; b = t; end
         3: begin r = p; g = q; b = v; end
         4: begin r = t; g = p; b = v; end
         default: begin r = v; g = p; b = q; end
      endcase
      res.red = to_byte(r);
      res.green = to_byte(g);
      res.blue = to_byte(b);
      return res;
   endfunction

   task automatic write_reg(fvc_pkg::csr_index_type idx, logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == fvc_pkg::CSR_SHOW_MODE) view_cost = value[0];
      else view_gain = value;
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [15:0] fx, logic [15:0] fy, logic [15:0] cost,
                             logic known, pixel_color_type given);
      pixel_color_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {cost, fy, fx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = known ? given : color_of_pixel(fx, fy, cost);
      color_queue.push_back(want);
   endtask

   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (color_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_vec();
      unique case ($urandom_range(3))
         0: return 16'($urandom_range(127)) - 16'd64;
         1: return 16'($urandom_range(4095)) - 16'd2048;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      pixel_color_type got;
      pixel_color_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[39:24]};
         if (color_queue.size() == 0) begin
            $error("unexpected transfer %h", rsp_tdata);
            error_count++;
         end else begin
            want = color_queue.pop_front();
            if (got.red !== want.red) begin
               $error("red expected %0d actual %0d", want.red, got.red);
               error_count++;
            end
            if (got.green !== want.green) begin
               $error("green expected %0d actual %0d", want.green, got.green);
               error_count++;
            end
            if (got.blue !== want.blue) begin
               $error("blue expected %0d actual %0d", want.blue, got.blue);
               error_count++;
            end
            if (got.gray !== want.gray) begin
               $error("gray expected %0d actual %0d", want.gray, got.gray);
               error_count++;
            end
         end
      end
   end

   stim_row_type stim_table [13] = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{8'd255, 8'd255, 8'd255, 16'd0}},
      '{16'h7FFF, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h8000, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h7FFF, 16'hFFFF, 1'b0, '0},
      '{16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
      '{16'h8000, 16'h8000, 16'h0000, 1'b0, '0},
      '{16'h7FFF, 16'h7FFF, 16'h0000, 1'b0, '0},
      '{16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0},
      '{16'h7FFF, 16'h8000, 16'h0000, 1'b0, '0},
      '{16'h0020, 16'hFFE0, 16'h0000, 1'b0, '0},
      '{16'hFFFF, 16'h0001, 16'h0000, 1'b0, '0},
      '{16'h0001, 16'hFFFF, 16'h0000, 1'b0, '0},
      '{16'h5555, 16'hAAAA, 16'h1234, 1'b0, '0}
   };

   initial begin
      pixel_color_type white;
      int phase;
      white = '{8'd255, 8'd255, 8'd255, 16'd0};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = fvc_pkg::CSR_SHOW_MODE;
      csr_data = '0;
      error_count = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      view_cost = 1'b0;
      view_gain = 16'd256;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i])
         send_pixel(stim_table[i].fx, stim_table[i].fy, stim_table[i].cost,
                    stim_table[i].known, stim_table[i].color);
      drain_pipe();
      write_reg(fvc_pkg::CSR_SHOW_MODE, 16'h0001);
      send_pixel(16'h0, 16'h0, 16'h0000, 1'b1, '0);
      send_pixel(16'h0, 16'h0, 16'h0100, 1'b1, '{8'd0, 8'd0, 8'd0, 16'd65535});
      send_pixel(16'h0, 16'h0, 16'h00FF, 1'b1, '{8'd0, 8'd0, 8'd0, 16'd65280});
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{8'd0, 8'd0, 8'd0, 16'd65535});
      drain_pipe();
      write_reg(fvc_pkg::CSR_GAIN, 16'h0000);
      send_pixel(16'h7FFF, 16'h8000, 16'hFFFF, 1'b1, '0);
      drain_pipe();
      write_reg(fvc_pkg::CSR_SHOW_MODE, 16'hFFFE);
      send_pixel(16'h7FFF, 16'h1234, 16'hFFFF, 1'b1, white);
      drain_pipe();
      write_reg(fvc_pkg::CSR_GAIN, 16'hFFFF);
      send_pixel(16'h0001, 16'h0000, 16'h0000, 1'b0, '0);
      send_pixel(16'h0000, 16'h0001, 16'h0000, 1'b0, '0);
      drain_pipe();

      for (phase = 0; phase < 12; phase++) begin
         unique case (phase % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 82; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 82; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         write_reg(fvc_pkg::CSR_SHOW_MODE, 16'($urandom_range(3) == 0));
         unique case (phase % 3)
            0: write_reg(fvc_pkg::CSR_GAIN, 16'($urandom));
            1: write_reg(fvc_pkg::CSR_GAIN, 16'($urandom_range(1023)));
            default: write_reg(fvc_pkg::CSR_GAIN, (phase < 6) ? 16'hFFFF : 16'd256);
         endcase
         for (int k = 0; k < 95; k++) begin
            send_pixel(rand_vec(), rand_vec(), 16'($urandom), 1'b0, '0);
            if (k == 50) begin
               req_tvalid <= 1'b0;
               while (color_queue.size() != 0) @(posedge clock);
            end
         end
         drain_pipe();
      end
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0 && color_queue.size() == 0) begin
         $display("flow_vector_to_color_core: match");
      end else begin
         $display("flow_vector_to_color_core: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("flow_vector_to_color_core: mismatch");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/fvc_pkg.sv
src/fvc_cordic_cell.sv
src/fvc_sqrt_cell.sv
src/flow_vector_to_color_core.sv
src/fvc_checker.sv
tb/tb_flow_vector_to_color_core.sv
